@@ rtl/rmt_pkg.sv @@
`default_nettype none
package rmt_pkg;

  localparam int MAX_ROOMS    = 16;
  localparam int MEMBER_SLOTS = 50;
  localparam int NAME_BYTES   = 20;

  localparam int IDX_W    = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int AGE_W    = IDX_W;
  localparam int COUNT_W  = 5;
  localparam int WAIT_W   = $clog2(MAX_ROOMS + 1);
  localparam int SCNT_W   = $clog2(MEMBER_SLOTS + 1);
  localparam int DEPTH    = MAX_ROOMS * MEMBER_SLOTS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CLIENT_W = 10;

  function automatic logic [63:0] name_mask(int first, int count);
    int keep;
    logic [63:0] m;
    m = '0;
    if (NAME_BYTES > first) begin
      keep = NAME_BYTES - first;
      if (keep > count) keep = count;
      if (keep >= 8) m = '1;
      else m = (64'd1 << (8 * keep)) - 64'd1;
    end
    return m;
  endfunction

  localparam logic [63:0] NAME_MASK_LOW  = name_mask(0, 8);
  localparam logic [63:0] NAME_MASK_MID  = name_mask(8, 8);
  localparam logic [31:0] NAME_MASK_HIGH = 32'(name_mask(16, 4));

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_DELETE = 3'd1,
    OP_JOIN   = 3'd2,
    OP_LEAVE  = 3'd3,
    OP_CLOSE  = 3'd4,
    OP_COUNT  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NOT_EMPTY  = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_FILL,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_idx;
    logic [AGE_W-1:0] match_age;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } chain_t;

  typedef struct packed {
    logic             create;
    logic             remove;
    logic [IDX_W-1:0] idx;
    logic [AGE_W-1:0] del_age;
    logic [63:0]      name_low;
    logic [63:0]      name_mid;
    logic [31:0]      name_high;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/room_membership_table.sv @@
`default_nettype none
// Every request passes along the room cell chain and through a decide state; delete, count
// and missed lookups then go to the output register. Create first clears the room's member
// slots, and join, leave and close first scan the room's slots.
// One request at a time: the input stalls until the result is loaded for output.
// Reset clears all room valid bits, the room count and the handshake state; input stalls.
module room_membership_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [63:0] room_name_low,
  input  wire logic [63:0] room_name_mid,
  input  wire logic [31:0] room_name_high,
  input  wire logic [9:0]  client_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [4:0]       room_count
);

  rmt_pkg::state_t                   state, state_next;
  logic [2:0]                        op;
  logic [63:0]                       req_low, req_mid;
  logic [31:0]                       req_high;
  logic [rmt_pkg::CLIENT_W-1:0]      client;
  logic [rmt_pkg::WAIT_W-1:0]        wait_cnt;
  logic [rmt_pkg::ADDR_W-1:0]        base, base_next;
  logic [rmt_pkg::SCNT_W-1:0]        slot_cnt;
  logic [rmt_pkg::SCNT_W-1:0]        rd_slot;
  logic                              rd_valid;
  logic [rmt_pkg::CLIENT_W-1:0]      rd_data;
  rmt_pkg::status_t                  status_r, status_next;
  logic [rmt_pkg::COUNT_W-1:0]       rooms_in_use;
  logic                              we;
  logic [rmt_pkg::ADDR_W-1:0]        waddr, raddr;
  logic [rmt_pkg::CLIENT_W-1:0]      wdata;
  logic                              load_out;
  rmt_pkg::cmd_t                     cmd;
  rmt_pkg::chain_t                   chain [0:rmt_pkg::MAX_ROOMS];
  rmt_pkg::chain_t                   found;

  logic [rmt_pkg::CLIENT_W-1:0] slots_mem [0:rmt_pkg::DEPTH-1];

  assign chain[0] = '0;
  assign found    = chain[rmt_pkg::MAX_ROOMS];

  for (genvar i = 0; i < rmt_pkg::MAX_ROOMS; i++) begin : g_cell
    rmt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (rmt_pkg::IDX_W'(i)),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_comb begin
    state_next    = state;
    status_next   = status_r;
    in_stall      = rst || (state != rmt_pkg::S_IDLE);
    load_out      = 1'b0;
    we            = 1'b0;
    waddr         = base + rmt_pkg::ADDR_W'(slot_cnt);
    wdata         = '0;
    raddr         = base + rmt_pkg::ADDR_W'(slot_cnt);
    base_next     = base;
    cmd.create    = 1'b0;
    cmd.remove    = 1'b0;
    cmd.idx       = found.match_idx;
    cmd.del_age   = found.match_age;
    cmd.name_low  = req_low;
    cmd.name_mid  = req_mid;
    cmd.name_high = req_high;
    unique case (state)
      rmt_pkg::S_IDLE: begin
        if (in_valid) state_next = rmt_pkg::S_SEARCH;
      end
      rmt_pkg::S_SEARCH: begin
        if (wait_cnt == rmt_pkg::WAIT_W'(rmt_pkg::MAX_ROOMS)) state_next = rmt_pkg::S_DECIDE;
      end
      rmt_pkg::S_DECIDE: begin
        status_next = rmt_pkg::ST_OK;
        base_next   = rmt_pkg::ADDR_W'(found.match_idx * rmt_pkg::MEMBER_SLOTS);
        state_next  = rmt_pkg::S_DONE;
        priority case (op)
          rmt_pkg::OP_CREATE: begin
            base_next = rmt_pkg::ADDR_W'(found.free_idx * rmt_pkg::MEMBER_SLOTS);
            if (!found.free_found) begin
              status_next = rmt_pkg::ST_TABLE_FULL;
            end else begin
              cmd.create = 1'b1;
              cmd.idx    = found.free_idx;
              state_next = rmt_pkg::S_FILL;
            end
          end
          rmt_pkg::OP_DELETE: begin
            if (!found.match_found) status_next = rmt_pkg::ST_NOT_FOUND;
            else cmd.remove = 1'b1;
          end
          rmt_pkg::OP_JOIN, rmt_pkg::OP_LEAVE, rmt_pkg::OP_CLOSE: begin
            if (!found.match_found) status_next = rmt_pkg::ST_NOT_FOUND;
            else state_next = rmt_pkg::S_SCAN;
          end
          default: ;
        endcase
      end
      rmt_pkg::S_FILL: begin
        we    = 1'b1;
        wdata = (slot_cnt == '0) ? client : '0;
        if (slot_cnt == rmt_pkg::SCNT_W'(rmt_pkg::MEMBER_SLOTS - 1))
          state_next = rmt_pkg::S_DONE;
      end
      rmt_pkg::S_SCAN: begin
        waddr = base + rmt_pkg::ADDR_W'(rd_slot);
        if (rd_valid) begin
          priority if (op == rmt_pkg::OP_JOIN && rd_data == '0) begin
            we          = 1'b1;
            wdata       = client;
            status_next = rmt_pkg::ST_OK;
            state_next  = rmt_pkg::S_DONE;
          end else if (op == rmt_pkg::OP_CLOSE && rd_data != '0) begin
            status_next = rmt_pkg::ST_NOT_EMPTY;
            state_next  = rmt_pkg::S_DONE;
          end else if (rd_slot == rmt_pkg::SCNT_W'(rmt_pkg::MEMBER_SLOTS - 1)) begin
            state_next = rmt_pkg::S_DONE;
            if (op == rmt_pkg::OP_JOIN) status_next = rmt_pkg::ST_FULL;
            if (op == rmt_pkg::OP_CLOSE) cmd.remove = 1'b1;
            if (op == rmt_pkg::OP_LEAVE && rd_data == client) we = 1'b1;
          end else begin
            if (op == rmt_pkg::OP_LEAVE && rd_data == client) we = 1'b1;
          end
        end
      end
      rmt_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = rmt_pkg::S_IDLE;
        end
      end
      default: state_next = rmt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rmt_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (we) slots_mem[waddr] <= wdata;
    rd_data <= slots_mem[raddr];
  end

  always_ff @(posedge clk) begin
    status_r <= status_next;
    base     <= base_next;
    if (state == rmt_pkg::S_IDLE && in_valid) begin
      op       <= operation;
      req_low  <= room_name_low & rmt_pkg::NAME_MASK_LOW;
      req_mid  <= room_name_mid & rmt_pkg::NAME_MASK_MID;
      req_high <= room_name_high & rmt_pkg::NAME_MASK_HIGH;
      client   <= client_id;
    end
    if (state == rmt_pkg::S_SEARCH) wait_cnt <= wait_cnt + 1'b1;
    else wait_cnt <= '0;
    if (state == rmt_pkg::S_DECIDE) begin
      slot_cnt <= '0;
      rd_valid <= 1'b0;
    end else if (state == rmt_pkg::S_FILL) begin
      slot_cnt <= slot_cnt + 1'b1;
    end else if (state == rmt_pkg::S_SCAN) begin
      rd_valid <= (slot_cnt < rmt_pkg::SCNT_W'(rmt_pkg::MEMBER_SLOTS));
      rd_slot  <= slot_cnt;
      if (slot_cnt < rmt_pkg::SCNT_W'(rmt_pkg::MEMBER_SLOTS)) slot_cnt <= slot_cnt + 1'b1;
    end
    if (load_out) begin
      status     <= status_r;
      room_count <= rooms_in_use;
    end
    if (rst) begin
      rooms_in_use <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.create) rooms_in_use <= rooms_in_use + 1'b1;
      else if (cmd.remove && rooms_in_use != '0) rooms_in_use <= rooms_in_use - 1'b1;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rmt_cell.sv @@
`default_nettype none
module rmt_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [rmt_pkg::IDX_W-1:0] cell_idx,
  input  wire rmt_pkg::cmd_t       cmd,
  input  wire rmt_pkg::chain_t     chain_in,
  output rmt_pkg::chain_t          chain_out
);

  logic                        valid;
  logic [63:0]                 name_low;
  logic [63:0]                 name_mid;
  logic [31:0]                 name_high;
  logic [rmt_pkg::AGE_W-1:0]   age;
  logic                        hit;
  rmt_pkg::chain_t             chain_next;

  always_comb begin
    hit = valid && (name_low == cmd.name_low) && (name_mid == cmd.name_mid)
          && (name_high == cmd.name_high);
    chain_next = chain_in;
    if (hit && (!chain_in.match_found || age < chain_in.match_age)) begin
      chain_next.match_found = 1'b1;
      chain_next.match_idx   = cell_idx;
      chain_next.match_age   = age;
    end
    if (!chain_in.free_found && !valid) begin
      chain_next.free_found = 1'b1;
      chain_next.free_idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    chain_out <= chain_next;
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.create) begin
      if (cmd.idx == cell_idx) begin
        valid     <= 1'b1;
        name_low  <= cmd.name_low;
        name_mid  <= cmd.name_mid;
        name_high <= cmd.name_high;
        age       <= '0;
      end else if (valid) begin
        age <= age + 1'b1;
      end
    end else if (cmd.remove) begin
      if (cmd.idx == cell_idx) begin
        valid <= 1'b0;
      end else if (valid && age > cmd.del_age) begin
        age <= age - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ bench/rmt_checker.sv @@
`timescale 1ns / 100ps
module rmt_checker
  import rmt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [63:0] room_name_low,
  input  wire logic [63:0] room_name_mid,
  input  wire logic [31:0] room_name_high,
  input  wire logic [9:0]  client_id,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  status,
  input  wire logic [4:0]  room_count,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    status_t    st;
    logic [4:0] cnt;
  } answer_t;

  logic        room_live [MAX_ROOMS];
  logic [63:0] room_lo   [MAX_ROOMS];
  logic [63:0] room_mid  [MAX_ROOMS];
  logic [31:0] room_hi   [MAX_ROOMS];
  int          room_rank [MAX_ROOMS];
  logic [9:0]  members   [MAX_ROOMS][MEMBER_SLOTS];
  int          live_rooms;
  answer_t     answers_due[$];

  assign pending = answers_due.size();

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int newest_room(logic [63:0] lo, logic [63:0] md, logic [31:0] hi);
    int best;
    best = -1;
    for (int i = 0; i < MAX_ROOMS; i++)
      if (room_live[i] && room_lo[i] == lo && room_mid[i] == md && room_hi[i] == hi)
        if (best < 0 || room_rank[i] < room_rank[best]) best = i;
    return best;
  endfunction

  function automatic void drop_room(int e);
    room_live[e] = 1'b0;
    for (int i = 0; i < MAX_ROOMS; i++)
      if (room_live[i] && room_rank[i] > room_rank[e]) room_rank[i]--;
    if (live_rooms > 0) live_rooms--;
  endfunction

  function automatic answer_t apply_request(logic [2:0] op, logic [63:0] lo,
                                            logic [63:0] md, logic [31:0] hi,
                                            logic [9:0] cl);
    answer_t a;
    int e;
    int slot_free;
    a.st = ST_OK;
    lo = lo & NAME_MASK_LOW;
    md = md & NAME_MASK_MID;
    hi = hi & NAME_MASK_HIGH;
    if (op == OP_CREATE) begin
      e = -1;
      for (int i = 0; i < MAX_ROOMS; i++)
        if (!room_live[i] && e < 0) e = i;
      if (e < 0) begin
        a.st = ST_TABLE_FULL;
      end else begin
        for (int i = 0; i < MAX_ROOMS; i++)
          if (room_live[i]) room_rank[i]++;
        room_live[e] = 1'b1;
        room_lo[e] = lo;
        room_mid[e] = md;
        room_hi[e] = hi;
        room_rank[e] = 0;
        for (int s = 0; s < MEMBER_SLOTS; s++) members[e][s] = '0;
        members[e][0] = cl;
        live_rooms++;
      end
    end else if (op >= OP_DELETE && op <= OP_CLOSE) begin
      e = newest_room(lo, md, hi);
      if (e < 0) begin
        a.st = ST_NOT_FOUND;
      end else if (op == OP_DELETE) begin
        drop_room(e);
      end else if (op == OP_JOIN) begin
        slot_free = -1;
        for (int s = 0; s < MEMBER_SLOTS; s++)
          if (members[e][s] == '0 && slot_free < 0) slot_free = s;
        if (slot_free < 0) a.st = ST_FULL;
        else members[e][slot_free] = cl;
      end else if (op == OP_LEAVE) begin
        for (int s = 0; s < MEMBER_SLOTS; s++)
          if (members[e][s] == cl) members[e][s] = '0;
      end else begin
        for (int s = 0; s < MEMBER_SLOTS; s++)
          if (members[e][s] != '0) a.st = ST_NOT_EMPTY;
        if (a.st == ST_OK) drop_room(e);
      end
    end
    a.cnt = live_rooms[4:0];
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < MAX_ROOMS; i++) room_live[i] <= 1'b0;
      live_rooms = 0;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall)
        answers_due.push_back(apply_request(operation, room_name_low, room_name_mid,
                                            room_name_high, client_id));
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          report("unexpected beat", status, 0);
        end else begin
          want = answers_due.pop_front();
          if (status !== want.st) report("status", status, want.st);
          if (room_count !== want.cnt) report("room_count", room_count, want.cnt);
        end
      end
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
module tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [63:0] room_name_low = '0;
  logic [63:0] room_name_mid = '0;
  logic [31:0] room_name_high = '0;
  logic [9:0]  client_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [4:0]  room_count;
  int          fail_count;
  int          pending;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 68;
  bit          hold_recv = 1'b0;
  logic [63:0] pool_lo [8];
  logic [63:0] pool_mid [8];
  logic [31:0] pool_hi [8];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  room_membership_table u_dut (.*);

  rmt_checker u_chk (.*);

  always @(posedge clk) begin
    if (hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_beat(input logic [2:0] op, input logic [63:0] lo,
                           input logic [63:0] md, input logic [31:0] hi,
                           input logic [9:0] cl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation <= op;
    room_name_low <= lo;
    room_name_mid <= md;
    room_name_high <= hi;
    client_id <= cl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pooled(input logic [2:0] op, input logic [9:0] cl);
    int k;
    k = $urandom_range(7);
    send_beat(op, pool_lo[k], pool_mid[k], pool_hi[k], cl);
  endtask

  task automatic send_random(input int n);
    int r;
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25) op = rmt_pkg::OP_CREATE;
      else if (r < 55) op = rmt_pkg::OP_JOIN;
      else if (r < 70) op = rmt_pkg::OP_LEAVE;
      else if (r < 80) op = rmt_pkg::OP_CLOSE;
      else if (r < 90) op = rmt_pkg::OP_DELETE;
      else op = 3'($urandom_range(7));
      if ($urandom_range(9) == 0)
        send_beat(op, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                  10'($urandom_range(1023)));
      else if ($urandom_range(3) == 0)
        send_pooled(op, 10'($urandom_range(1023)));
      else
        send_pooled(op, 10'($urandom_range(1, 12)));
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    for (int k = 0; k < 8; k++) begin
      pool_lo[k] = {$urandom, $urandom};
      pool_mid[k] = {$urandom, $urandom};
      pool_hi[k] = $urandom;
    end
    pool_lo[0] = '0; pool_mid[0] = '0; pool_hi[0] = '0;
    pool_lo[1] = '1; pool_mid[1] = '1; pool_hi[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // absent room for every lookup op, then extremes and client zero
    for (int op = rmt_pkg::OP_DELETE; op <= rmt_pkg::OP_CLOSE; op++)
      send_beat(3'(op), '1, '1, '1, 10'd5);
    send_beat(rmt_pkg::OP_CREATE, '1, '1, '1, 10'd1023);
    send_beat(rmt_pkg::OP_CREATE, '1, '1, '1, 10'd0);
    send_beat(rmt_pkg::OP_CLOSE, '1, '1, '1, 10'd0);
    send_beat(rmt_pkg::OP_JOIN, '1, '1, '1, 10'd0);
    send_beat(rmt_pkg::OP_DELETE, '1, '1, '1, 10'd0);
    send_beat(rmt_pkg::OP_CLOSE, '1, '1, '1, 10'd0);
    send_beat(rmt_pkg::OP_LEAVE, '0, '0, '0, 10'd3);
    send_beat(rmt_pkg::OP_COUNT, '0, '0, '0, 10'd0);
    send_beat(3'd6, '0, '0, '0, 10'd0);
    send_beat(3'd7, '0, '0, '0, 10'd0);
    // fill one room, then the table
    send_beat(rmt_pkg::OP_CREATE, '0, '0, '0, 10'd7);
    for (int s = 0; s < rmt_pkg::MEMBER_SLOTS; s++)
      send_beat(rmt_pkg::OP_JOIN, '0, '0, '0, 10'd9);
    send_beat(rmt_pkg::OP_LEAVE, '0, '0, '0, 10'd9);
    send_beat(rmt_pkg::OP_LEAVE, '0, '0, '0, 10'd7);
    for (int i = 0; i < rmt_pkg::MAX_ROOMS + 1; i++) send_pooled(rmt_pkg::OP_CREATE, 10'd2);
    drain();
    send_random(500);
    // long receiver hold while requests keep coming
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      send_random(20);
    join
    drain();
    send_idle_pct = 68;
    recv_idle_pct = 16;
    send_random(550);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(500);
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ room_membership_table.f @@
rtl/rmt_pkg.sv
rtl/rmt_cell.sv
rtl/room_membership_table.sv
bench/rmt_checker.sv
bench/tb.sv
